@@ sv/pdm_pkg.sv @@
// Shared types, constants and a helper function for the press duration meter.
package pdm_pkg;

	// Timer ticks in one millisecond and number of multiplexed digits
	localparam int unsigned TICKS_PER_MS = 16000;
	localparam int unsigned DIGIT_COUNT  = 4;

	localparam int unsigned MS_W    = 19;
	localparam int unsigned TIMER_W = 32;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned POS_W   = 2;
	localparam int unsigned EN_W    = 4;

	// Press time saturates at the top of the 19-bit range
	localparam logic [MS_W-1:0] PRESS_MAX = '1;

	// Operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	typedef logic [MS_W-1:0]    ms_t;
	typedef logic [TIMER_W-1:0] ticks_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SEG_W-1:0]   seg_t;
	typedef logic [POS_W-1:0]   pos_t;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic fall;    // falling edge that ends a press
		logic scan;    // display scan step
		pos_t pos;     // digit driven by a scan step
		logic meas;    // press in progress after this item
	} ctl_t;

	// Seven-segment pattern, bit0=a .. bit6=g
	function automatic seg_t seg_of(input digit_t d);
		seg_t s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ sv/pdm_div.sv @@
// Two-stage divider of the elapsed ticks by the ticks-per-ms constant, saturated to 19 bits.
module pdm_div
	import pdm_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  ticks_t ticks,
	output ms_t    ms
);

	// Reciprocal with 32 + ceil(log2 D) fraction bits gives an exact floor for 32-bit input
	localparam int unsigned SHIFT = 32 + $clog2(TICKS_PER_MS);
	localparam logic [65:0] RECIP_FULL =
		((66'd1 << SHIFT) + 66'(TICKS_PER_MS) - 66'd1) / 66'(TICKS_PER_MS);
	localparam logic [32:0] RECIP = RECIP_FULL[32:0];

	logic [48:0] prod_hi_s1;
	logic [48:0] prod_lo_s1;
	logic [64:0] prod_sum;
	logic [32:0] quot;

	// Partial products on the two 16-bit halves of the tick count
	always_ff @(posedge clk) begin
		if (en) begin
			prod_hi_s1 <= 49'(ticks[31:16]) * 49'(RECIP);
			prod_lo_s1 <= 49'(ticks[15:0]) * 49'(RECIP);
		end
	end

	// Recombine, shift out the fraction and saturate
	assign prod_sum = {prod_hi_s1, 16'd0} + {16'd0, prod_lo_s1};
	assign quot     = 33'(prod_sum >> SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			ms <= (quot > 33'(PRESS_MAX)) ? PRESS_MAX : quot[MS_W-1:0];
		end
	end

endmodule

@@ sv/pdm_bcd.sv @@
// Three-stage split of the press time into its four low decimal digits.
module pdm_bcd
	import pdm_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  ms_t    ms,
	output digit_t digits [4]
);

	// Reciprocals with 32 fraction bits, exact over the value ranges used here
	localparam logic [63:0] M_10000 = ((64'd1 << 32) + 64'd9999) / 64'd10000;
	localparam logic [63:0] M_1000  = ((64'd1 << 32) + 64'd999) / 64'd1000;
	localparam logic [63:0] M_100   = ((64'd1 << 32) + 64'd99) / 64'd100;
	localparam logic [63:0] M_10    = ((64'd1 << 32) + 64'd9) / 64'd10;

	logic [5:0]  thou10_s1;
	ms_t         ms_s1;
	logic [13:0] rem_s2;
	logic [13:0] rem_s3;
	logic [9:0]  a1_s3;
	logic [6:0]  a2_s3;
	logic [3:0]  a3_s3;

	logic [37:0] p10000;
	logic [42:0] p10;
	logic [39:0] p100;
	logic [36:0] p1000;

	// Stage 1: ms / 10000
	assign p10000 = 38'(ms) * 38'(M_10000[18:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			thou10_s1 <= p10000[37:32];
			ms_s1     <= ms;
		end
	end

	// Stage 2: ms mod 10000
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= 14'(ms_s1 - MS_W'(thou10_s1 * 14'd10000));
		end
	end

	// Stage 3: remainder / 10, / 100, / 1000
	assign p10   = 43'(rem_s2) * 43'(M_10[28:0]);
	assign p100  = 40'(rem_s2) * 40'(M_100[25:0]);
	assign p1000 = 37'(rem_s2) * 37'(M_1000[22:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3 <= rem_s2;
			a1_s3  <= p10[41:32];
			a2_s3  <= p100[38:32];
			a3_s3  <= p1000[35:32];
		end
	end

	// Digits from neighboring quotients
	assign digits[0] = DIGIT_W'(rem_s3 - 14'(a1_s3 * 4'd10));
	assign digits[1] = DIGIT_W'(a1_s3 - 10'(a2_s3 * 4'd10));
	assign digits[2] = DIGIT_W'(a2_s3 - 7'(a3_s3 * 4'd10));
	assign digits[3] = a3_s3;

endmodule

@@ sv/press_duration_meter_seven_segment.sv @@
// Press duration meter: button edge timing, tick-to-ms divide and 4-digit display scan.
//
// Input channel (in_valid / in_stall): one item per transfer. op selects a button
// edge event (button_level, timer_value) or a display scan step.
// Output channel (out_valid / out_stall): one result per input item, in order:
// digit_enable and segments for scan steps (zero for edges), press_ms and measuring
// as they stand after the item.
// Throughput: one item per cycle while no receiver stall holds the pipeline. The item
// flows through an eight-register pipeline (input register, an elapsed-tick stage,
// two divider stages, three decimal-split stages and the output register); the press
// time and its digits are written back at the last decimal-split stage, so later scan
// steps always see the latest measurement.
// Receiver stall: while the output register holds an untaken result and
// out_stall is high, the whole pipeline holds and in_stall is raised in the
// same cycle.
// Reset (arst_n low): pipeline emptied, no press in progress, press time 0,
// scan position on the ones digit.
module press_duration_meter_seven_segment
	import pdm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic                button_level,
	input  logic [TIMER_W-1:0]  timer_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [EN_W-1:0]     digit_enable,
	output logic [SEG_W-1:0]    segments,
	output logic [MS_W-1:0]     press_ms,
	output logic                measuring
);

	logic adv;

	// Input register
	logic   valid_s1;
	logic   op_s1;
	logic   level_s1;
	ticks_t timer_s1;

	// Measurement state
	ticks_t start_q;
	logic   pressed_q;
	pos_t   scan_q;
	ms_t    press_q;
	digit_t digits_q [4];

	// Pipeline control and payload
	logic   valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	ctl_t   ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	ticks_t ticks_s2;
	ms_t    ms_s4;
	ms_t    ms_s5, ms_s6, ms_s7;
	digit_t new_digits [4];

	// First-stage logic
	ctl_t   ctl_in;
	ticks_t ticks_in;
	pos_t   pos_cur;
	pos_t   pos_next;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= op;
			level_s1 <= button_level;
			timer_s1 <= timer_value;
		end
	end

	// Edge decode, elapsed ticks with the one-short wrap form, scan position
	always_comb begin
		pos_cur = (32'(scan_q) >= DIGIT_COUNT) ? '0 : scan_q;
		pos_next = (32'(pos_cur) + 32'd1 >= DIGIT_COUNT) ? '0 : POS_W'(pos_cur + 2'd1);
		if (timer_s1 >= start_q) begin
			ticks_in = timer_s1 - start_q;
		end else begin
			ticks_in = timer_s1 + ~start_q;
		end
		ctl_in.fall = (op_s1 == OP_EDGE) && !level_s1 && pressed_q;
		ctl_in.scan = (op_s1 == OP_SCAN);
		ctl_in.pos  = pos_cur;
		if (op_s1 == OP_EDGE) begin
			ctl_in.meas = level_s1;
		end else begin
			ctl_in.meas = pressed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			pressed_q <= 1'b0;
			scan_q    <= '0;
		end else if (adv && valid_s1) begin
			if (op_s1 == OP_SCAN) begin
				scan_q <= pos_next;
			end else if (level_s1) begin
				start_q   <= timer_s1;
				pressed_q <= 1'b1;
			end else begin
				pressed_q <= 1'b0;
			end
		end
	end

	// Valid bits down the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			out_valid <= valid_s7;
		end
	end

	// Control and press-time payload alongside the arithmetic units
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2   <= ctl_in;
			ticks_s2 <= ticks_in;
			ctl_s3   <= ctl_s2;
			ctl_s4   <= ctl_s3;
			ctl_s5   <= ctl_s4;
			ctl_s6   <= ctl_s5;
			ctl_s7   <= ctl_s6;
			ms_s5    <= ms_s4;
			ms_s6    <= ms_s5;
			ms_s7    <= ms_s6;
		end
	end

	pdm_div u_div (
		.clk   (clk),
		.en    (adv),
		.ticks (ticks_s2),
		.ms    (ms_s4)
	);

	pdm_bcd u_bcd (
		.clk    (clk),
		.en     (adv),
		.ms     (ms_s4),
		.digits (new_digits)
	);

	// Write back a finished measurement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= '0;
			for (int i = 0; i < 4; i++) begin
				digits_q[i] <= '0;
			end
		end else if (adv && valid_s7 && ctl_s7.fall) begin
			press_q <= ms_s7;
			for (int i = 0; i < 4; i++) begin
				digits_q[i] <= new_digits[i];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			press_ms  <= ctl_s7.fall ? ms_s7 : press_q;
			measuring <= ctl_s7.meas;
			if (ctl_s7.scan) begin
				digit_enable <= EN_W'(1) << ctl_s7.pos;
				segments     <= seg_of(digits_q[ctl_s7.pos]);
			end else begin
				digit_enable <= '0;
				segments     <= '0;
			end
		end
	end

endmodule

@@ sv/pdm_chk.sv @@
// Port-level checker for the press duration meter, bound to the top level.
module pdm_chk
	import pdm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                op,
	input logic                button_level,
	input logic [TIMER_W-1:0]  timer_value,
	input logic                out_valid,
	input logic                out_stall,
	input logic [EN_W-1:0]     digit_enable,
	input logic [SEG_W-1:0]    segments,
	input logic [MS_W-1:0]     press_ms,
	input logic                measuring
);

	// A held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_enable) &&
			$stable(segments) && $stable(press_ms) && $stable(measuring))
		else $error("stalled result changed");

	// A held result holds the input side too
	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

	// Input is taken whenever the output side can move
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |-> !in_stall)
		else $error("input stalled with free output");

	// A scan result drives exactly one digit with a lit pattern
	a_scan_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (digit_enable != '0) |-> $onehot(digit_enable) && (segments != '0))
		else $error("bad scan result");

endmodule

bind press_duration_meter_seven_segment pdm_chk u_pdm_chk (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the press duration meter with seven-segment scan.
module tb_top;
	import pdm_pkg::*;

	// Button levels carried by an edge event
	localparam logic BTN_DOWN = 1'b1;
	localparam logic BTN_UP   = 1'b0;

	localparam int unsigned HOLD_LEN    = 150;   // long receiver hold-off, in cycles
	localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no transfer before giving up
	localparam int unsigned REPORT_MAX  = 10;

	typedef struct packed {
		logic [EN_W-1:0] en;
		seg_t            seg;
		ms_t             ms;
		logic            meas;
	} meter_out_t;

	// Tracks meter state and holds the readings expected from the block, in order
	class meter_scoreboard;
		ticks_t           start_cnt;
		logic             pressed;
		ms_t              shown_ms;
		int unsigned      scan_pos;
		meter_out_t       readings[$];
		int unsigned      errors;
		int unsigned      checked;
		int unsigned      edges;
		int unsigned      presses;
		int unsigned      wraps;
		int unsigned      scans;

		function new();
			start_cnt = '0;
			pressed   = 1'b0;
			shown_ms  = '0;
			scan_pos  = 0;
			errors    = 0;
			checked   = 0;
			edges     = 0;
			presses   = 0;
			wraps     = 0;
			scans     = 0;
		endfunction

		function seg_t digit_glyph(int unsigned d);
			case (d)
				0:       return 7'h3F;
				1:       return 7'h06;
				2:       return 7'h5B;
				3:       return 7'h4F;
				4:       return 7'h66;
				5:       return 7'h6D;
				6:       return 7'h7D;
				7:       return 7'h07;
				8:       return 7'h7F;
				default: return 7'h6F;
			endcase
		endfunction

		function int unsigned pending();
			return readings.size();
		endfunction

		// Update the meter for one accepted input transfer and queue its reading
		function void note_input(logic o, logic lvl, ticks_t now);
			meter_out_t  r;
			ticks_t      elapsed;
			ticks_t      quot;
			int unsigned ndig;
			int unsigned pos;
			int unsigned val;
			r = '0;
			if (o == OP_EDGE) begin
				edges++;
				if (lvl == BTN_DOWN) begin
					start_cnt = now;
					pressed   = 1'b1;
				end else if (pressed) begin
					// wrapped count loses one tick, as the meter defines it
					if (now >= start_cnt)
						elapsed = now - start_cnt;
					else begin
						elapsed = 32'hFFFF_FFFF - start_cnt + now;
						wraps++;
					end
					quot     = elapsed / ((TICKS_PER_MS == 0) ? 1 : TICKS_PER_MS);
					shown_ms = (quot > PRESS_MAX) ? PRESS_MAX : quot[MS_W-1:0];
					pressed  = 1'b0;
					presses++;
				end
			end else begin
				scans++;
				ndig = (DIGIT_COUNT < 1 || DIGIT_COUNT > 4) ? 4 : DIGIT_COUNT;
				pos  = (scan_pos >= ndig) ? 0 : scan_pos;
				val  = 32'(shown_ms);
				repeat (pos) val = val / 10;
				r.en     = 4'b0001 << pos;
				r.seg    = digit_glyph(val % 10);
				scan_pos = (pos + 1 >= ndig) ? 0 : pos + 1;
			end
			r.ms   = shown_ms;
			r.meas = pressed;
			readings.push_back(r);
		endfunction

		// Compare one output transfer with the oldest queued reading
		function void check_result(meter_out_t got);
			meter_out_t want;
			if (readings.size() == 0) begin
				if (errors < REPORT_MAX)
					$display("[%0t] unexpected output: en=%h seg=%h ms=%0d meas=%b",
						$time, got.en, got.seg, got.ms, got.meas);
				errors++;
				return;
			end
			want = readings.pop_front();
			checked++;
			if (got.en !== want.en || got.seg !== want.seg || got.ms !== want.ms ||
					got.meas !== want.meas) begin
				if (errors < REPORT_MAX)
					$display({"[%0t] mismatch: exp en=%h seg=%h ms=%0d meas=%b, ",
						"got en=%h seg=%h ms=%0d meas=%b"},
						$time, want.en, want.seg, want.ms, want.meas,
						got.en, got.seg, got.ms, got.meas);
				errors++;
			end
		endfunction
	endclass

	logic            clk          = 1'b0;
	logic            arst_n       = 1'b0;
	logic            in_valid     = 1'b0;
	logic            in_stall;
	logic            op           = OP_EDGE;
	logic            button_level = BTN_UP;
	ticks_t          timer_value  = '0;
	logic            out_valid;
	logic            out_stall    = 1'b0;
	logic [EN_W-1:0] digit_enable;
	seg_t            segments;
	ms_t             press_ms;
	logic            measuring;

	meter_scoreboard sb = new();
	int unsigned     idle_pct    = 0;
	int unsigned     stall_pct   = 0;
	int unsigned     sent        = 0;
	logic            squeeze     = 1'b0;
	int unsigned     hold_count  = 0;
	int unsigned     quiet_cycles = 0;

	press_duration_meter_seven_segment dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.button_level (button_level),
		.timer_value  (timer_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.digit_enable (digit_enable),
		.segments     (segments),
		.press_ms     (press_ms),
		.measuring    (measuring)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one item, with a random gap first, and wait for its transfer
	task automatic send_item(input logic o, input logic lvl, input ticks_t tv);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid     <= 1'b1;
		op           <= o;
		button_level <= lvl;
		timer_value  <= tv;
		do @(posedge clk); while (in_stall);
		sb.note_input(o, lvl, tv);
		sent++;
	endtask

	// Corners: idle scans, stray release, restart, longest press, wrap, zero length
	task automatic run_directed();
		repeat (4) send_item(OP_SCAN, BTN_UP, '0);
		send_item(OP_EDGE, BTN_UP, 32'hFFFF_FFFF);
		send_item(OP_EDGE, BTN_DOWN, 32'h0000_5000);
		send_item(OP_EDGE, BTN_DOWN, 32'h0000_0000);
		send_item(OP_EDGE, BTN_UP, 32'hFFFF_FFFF);
		repeat (4) send_item(OP_SCAN, BTN_DOWN, 32'hFFFF_FFFF);
		send_item(OP_EDGE, BTN_DOWN, 32'hFFFF_C180);
		send_item(OP_EDGE, BTN_UP, 32'h0000_0000);
		send_item(OP_EDGE, BTN_DOWN, 32'd100);
		send_item(OP_EDGE, BTN_UP, 32'd100);
		send_item(OP_EDGE, BTN_DOWN, 32'd5);
		send_item(OP_EDGE, BTN_UP, 32'd4);
		send_item(OP_EDGE, BTN_DOWN, 32'd0);
		send_item(OP_EDGE, BTN_UP, 32'd19759999);
		repeat (4) send_item(OP_SCAN, BTN_UP, 32'h5A5A_A5A5);
	endtask

	// Mostly full press/release/scan sequences, some noise and broken ones
	task automatic random_group();
		ticks_t      t0;
		ticks_t      dur;
		int unsigned n;
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(1, 4);
			repeat (n) send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
		end else begin
			t0 = $urandom;
			send_item(OP_EDGE, BTN_DOWN, t0);
			n = $urandom_range(0, 2);
			repeat (n) send_item(OP_SCAN, 1'($urandom_range(1)), $urandom);
			if ($urandom_range(9) == 0) begin
				t0 = $urandom;
				send_item(OP_EDGE, BTN_DOWN, t0);
			end
			case ($urandom_range(9))
				0: dur = $urandom;
				1: dur = $urandom_range(268435) * TICKS_PER_MS + $urandom_range(TICKS_PER_MS - 1);
				2: dur = $urandom_range(TICKS_PER_MS * 3);
				default: dur = $urandom_range(9999) * TICKS_PER_MS +
					$urandom_range(TICKS_PER_MS - 1);
			endcase
			// a dropped release leaves the press open for the next group
			if ($urandom_range(19) != 0)
				send_item(OP_EDGE, BTN_UP, t0 + dur);
			n = $urandom_range(3, 8);
			repeat (n) send_item(OP_SCAN, 1'($urandom_range(1)), $urandom);
		end
	endtask

	// Output side: check transfers, stall at random or hold off on request
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(meter_out_t'{digit_enable, segments, press_ms, measuring});
		if (squeeze && hold_count < HOLD_LEN) begin
			out_stall  <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (!squeeze)
				hold_count <= 0;
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct  = 16;
		stall_pct = 53;
		run_directed();
		while (sent < 420) random_group();

		idle_pct  = 53;
		stall_pct = 16;
		while (sent < 840) random_group();

		// no idling; open with a long receiver hold-off so the pipeline backs up
		idle_pct  = 0;
		stall_pct = 0;
		squeeze  <= 1'b1;
		while (sent < 900) random_group();
		squeeze  <= 1'b0;
		while (sent < 1250) random_group();
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("Sent %0d items: %0d edge events (%0d timed presses, %0d wrapped counts),",
			sent, sb.edges, sb.presses, sb.wraps);
		$display("%0d scans; checked %0d outputs, %0d errors.",
			sb.scans, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
